FILE: hw/rtl/md5bs_pkg.sv
// ----------------------------------------------------------------------------
// md5bs_pkg
// shared types, constants and round tables of the md5 byte stream hasher
// ----------------------------------------------------------------------------
package md5bs_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam int unsigned MSG_WORDS = 16;
    localparam int unsigned ROUNDS    = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5bs_words_t;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by a given round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] j;
        logic [3:0] g;
        j = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: g = j;
            2'd1: g = 4'(4'(j * 4'd5) + 4'd1);
            2'd2: g = 4'(4'(j * 4'd3) + 4'd5);
            2'd3: g = 4'(j * 4'd7);
            default: g = j;
        endcase
        return g;
    endfunction

endpackage

FILE: hw/rtl/md5_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// md5_byte_stream_hasher_unit
// md5 hasher that takes a message one byte per item and emits the digest
// ----------------------------------------------------------------------------
// s_ channel: one item per message byte; s_tuser high marks s_tdata as a
// message byte, s_tlast marks the final item, which may carry no byte.
// m_ channel: four digest items, words a to d, index on m_tuser and
// m_tlast on word d; each word holds its bytes in little-endian order.
// a byte item is taken while idle; the byte that fills a 64-byte block
// starts a compression (a read-ahead step, 64 rounds through the single
// round unit, one chaining add), and no new item is taken until it ends.
// the final item passes a pad setup state, then 1 to 16 padding writes
// into the word ram and a compression, plus 16 writes and a second
// compression when 8 or fewer bytes of the block are free; then the four
// digest items.
// s_tready is high only while the block waits for an item; a stalled
// receiver holds the digest item on the m_ side until taken.
// reset returns the chaining words to the md5 initial vector and clears
// the bit count; after the last digest item the same happens.
// ----------------------------------------------------------------------------
module md5_byte_stream_hasher_unit
    import md5bs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [1:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROUND,
        ST_ADD,
        ST_PAD_INIT,
        ST_FILL,
        ST_OUT
    } state_t;

    state_t       state_reg, state_next;
    md5bs_words_t chain_reg, chain_next;
    md5bs_words_t work_reg, work_next;
    md5bs_words_t round_out;
    logic [63:0]  bit_count_reg, bit_count_next;
    logic [31:0]  asm_reg, asm_next;
    logic [5:0]   round_reg, round_next;
    logic [3:0]   wptr_reg, wptr_next;
    logic [1:0]   oi_reg, oi_next;
    logic         end_pending_reg, end_pending_next;
    logic         pad_mode_reg, pad_mode_next;
    logic         head_pending_reg, head_pending_next;
    logic         two_blk_reg, two_blk_next;

    logic         wr_en;
    logic [3:0]   wr_addr;
    logic [31:0]  wr_data;
    logic [3:0]   rd_addr;
    logic [31:0]  rd_data;
    logic [31:0]  pad_word;
    logic [5:0]   idx;
    logic [1:0]   lane;
    logic         s_acc;

    assign idx      = bit_count_reg[8:3];
    assign lane     = idx[1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = oi_reg;
    assign m_tlast  = (oi_reg == 2'd3);

    always_comb begin
        unique case (oi_reg)
            2'd0: m_tdata = chain_reg.a;
            2'd1: m_tdata = chain_reg.b;
            2'd2: m_tdata = chain_reg.c;
            2'd3: m_tdata = chain_reg.d;
            default: m_tdata = '0;
        endcase
    end

    // word holding the end marker: earlier bytes, then 0x80, then zeros
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (2'(l) < lane) begin
                pad_word[8*l +: 8] = asm_reg[8*l +: 8];
            end else if (2'(l) == lane) begin
                pad_word[8*l +: 8] = PAD_BYTE;
            end else begin
                pad_word[8*l +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_START: rd_addr = msg_index(6'd0);
            ST_ROUND: rd_addr = msg_index(6'(round_reg + 6'd1));
            default:  rd_addr = '0;
        endcase
    end

    md5bs_ram #(
        .WIDTH(32),
        .DEPTH(MSG_WORDS)
    ) u_msg_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    md5bs_round u_round (
        .cur     (work_reg),
        .msg_word(rd_data),
        .rnd     (round_reg),
        .nxt     (round_out)
    );

    always_comb begin
        state_next        = state_reg;
        chain_next        = chain_reg;
        work_next         = work_reg;
        bit_count_next    = bit_count_reg;
        asm_next          = asm_reg;
        round_next        = round_reg;
        wptr_next         = wptr_reg;
        oi_next           = oi_reg;
        end_pending_next  = end_pending_reg;
        pad_mode_next     = pad_mode_reg;
        head_pending_next = head_pending_reg;
        two_blk_next      = two_blk_reg;
        wr_en             = 1'b0;
        wr_addr           = wptr_reg;
        wr_data           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser) begin
                        asm_next[8*lane +: 8] = s_tdata;
                        bit_count_next        = bit_count_reg + 64'd8;
                        if (lane == 2'd3) begin
                            wr_en   = 1'b1;
                            wr_addr = idx[5:2];
                            wr_data = {s_tdata, asm_reg[23:0]};
                        end
                    end
                    if (s_tuser && idx == 6'd63) begin
                        end_pending_next = s_tlast;
                        pad_mode_next    = 1'b0;
                        state_next       = ST_START;
                    end else if (s_tlast) begin
                        state_next = ST_PAD_INIT;
                    end
                end
            end
            ST_PAD_INIT: begin
                wptr_next         = idx[5:2];
                head_pending_next = 1'b1;
                two_blk_next      = (idx[5:3] == 3'd7);
                state_next        = ST_FILL;
            end
            ST_FILL: begin
                wr_en = 1'b1;
                if (head_pending_reg) begin
                    wr_data = pad_word;
                end else if (!two_blk_reg && wptr_reg == 4'd14) begin
                    wr_data = bit_count_reg[31:0];
                end else if (!two_blk_reg && wptr_reg == 4'd15) begin
                    wr_data = bit_count_reg[63:32];
                end
                head_pending_next = 1'b0;
                wptr_next         = 4'(wptr_reg + 4'd1);
                if (wptr_reg == 4'd15) begin
                    pad_mode_next = 1'b1;
                    state_next    = ST_START;
                end
            end
            ST_START: begin
                work_next  = chain_reg;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                work_next  = round_out;
                round_next = 6'(round_reg + 6'd1);
                if (round_reg == 6'(ROUNDS - 1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                if (pad_mode_reg) begin
                    if (two_blk_reg) begin
                        two_blk_next = 1'b0;
                        wptr_next    = '0;
                        state_next   = ST_FILL;
                    end else begin
                        oi_next    = '0;
                        state_next = ST_OUT;
                    end
                end else if (end_pending_reg) begin
                    end_pending_next = 1'b0;
                    state_next       = ST_PAD_INIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    oi_next = 2'(oi_reg + 2'd1);
                    if (oi_reg == 2'd3) begin
                        chain_next     = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
                        bit_count_next = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            chain_reg        <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
            work_reg         <= '0;
            bit_count_reg    <= '0;
            round_reg        <= '0;
            wptr_reg         <= '0;
            oi_reg           <= '0;
            end_pending_reg  <= 1'b0;
            pad_mode_reg     <= 1'b0;
            head_pending_reg <= 1'b0;
            two_blk_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            chain_reg        <= chain_next;
            work_reg         <= work_next;
            bit_count_reg    <= bit_count_next;
            round_reg        <= round_next;
            wptr_reg         <= wptr_next;
            oi_reg           <= oi_next;
            end_pending_reg  <= end_pending_next;
            pad_mode_reg     <= pad_mode_next;
            head_pending_reg <= head_pending_next;
            two_blk_reg      <= two_blk_next;
        end
    end

    // byte lanes of the word being gathered
    always_ff @(posedge aclk) begin
        asm_reg <= asm_next;
    end

endmodule

FILE: hw/rtl/md5bs_ram.sv
// ----------------------------------------------------------------------------
// md5bs_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module md5bs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/md5bs_round.sv
// ----------------------------------------------------------------------------
// md5bs_round
// one md5 round step, shared by all 64 rounds of a compression
// ----------------------------------------------------------------------------
module md5bs_round
    import md5bs_pkg::*;
(
    input  md5bs_words_t cur,
    input  logic [31:0]  msg_word,
    input  logic [5:0]   rnd,
    output md5bs_words_t nxt
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [4:0]  sh;

    always_comb begin
        unique case (rnd[5:4])
            2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
            2'd1: f = (cur.b & cur.d) | (cur.c & ~cur.d);
            2'd2: f = cur.b ^ cur.c ^ cur.d;
            2'd3: f = cur.c ^ (cur.b | ~cur.d);
            default: f = '0;
        endcase
        sh       = ROT_AMT[{rnd[5:4], rnd[1:0]}];
        sum      = cur.a + f + ROUND_K[rnd] + msg_word;
        rot_wide = {sum, sum} << sh;
        nxt.a    = cur.d;
        nxt.b    = cur.b + rot_wide[63:32];
        nxt.c    = cur.b;
        nxt.d    = cur.c;
    end

endmodule

FILE: hw/rtl/md5bs_checker.sv
// ----------------------------------------------------------------------------
// md5bs_checker
// port-level checks of the md5 byte stream hasher, bound to the top level
// ----------------------------------------------------------------------------
module md5bs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // input side is closed while the digest goes out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest item pending");

    // last flag only on word d
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
        else $error("last flag does not match word index");

    // digest words follow one another in order
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tuser == 2'($past(m_tuser) + 2'd1)))
        else $error("digest words out of order");

    // digest ends after word d and input reopens
    a_end_digest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("digest did not end after last word");

    // stalled digest item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled digest item changed");

endmodule

bind md5_byte_stream_hasher_unit md5bs_checker u_md5bs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

FILE: bench/md5_byte_stream_hasher_unit_test.sv
// ----------------------------------------------------------------------------
// md5_byte_stream_hasher_unit_test
// self-checking bench for the md5 byte stream hasher: messages of assorted
// lengths go in one byte per item and each digest is checked word by word
// against an md5 computed inside the bench, with random sender bursts and
// receiver stalls
// ----------------------------------------------------------------------------
module md5_byte_stream_hasher_unit_test;

    localparam int unsigned STOP_CYCLES = 400000;
    localparam int unsigned ITEM_TARGET = 330;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned REPORT_LIMIT = 10;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    localparam logic [31:0] ROUND_SINE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int unsigned ROUND_SHIFT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_item_t;

    class digest_board;
        logic [31:0]  chain [4];
        logic [7:0]   block_bytes [64];
        logic [63:0]  msg_bits;
        digest_item_t digest_queue [$];
        int unsigned  errors;

        function void restart();
            chain[0] = INIT_A;
            chain[1] = INIT_B;
            chain[2] = INIT_C;
            chain[3] = INIT_D;
            msg_bits = '0;
        endfunction

        function void compress_block();
            logic [31:0] m [16];
            logic [31:0] a, b, c, d, f, t, sum, rot;
            int unsigned g, s;
            for (int i = 0; i < 16; i++) begin
                m[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                        block_bytes[4*i+1], block_bytes[4*i]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++) begin
                case (i / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        g = (5 * i + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                s = ROUND_SHIFT[(i / 16) * 4 + (i % 4)];
                sum = a + f + ROUND_SINE[i] + m[g];
                rot = (sum << s) | (sum >> (32 - s));
                t = d;
                d = c;
                c = b;
                b = b + rot;
                a = t;
            end
            chain[0] = chain[0] + a;
            chain[1] = chain[1] + b;
            chain[2] = chain[2] + c;
            chain[3] = chain[3] + d;
        endfunction

        function void note_item(logic [7:0] data, logic has_byte, logic ends);
            int unsigned pos;
            digest_item_t item;
            if (has_byte) begin
                pos = 32'(msg_bits[8:3]);
                block_bytes[pos] = data;
                msg_bits = msg_bits + 64'd8;
                if (pos == 63)
                    compress_block();
            end
            if (!ends)
                return;
            pos = 32'(msg_bits[8:3]);
            block_bytes[pos] = PAD_MARK;
            for (int i = pos + 1; i < 64; i++)
                block_bytes[i] = 8'h00;
            if (pos >= 56) begin
                compress_block();
                for (int i = 0; i < 64; i++)
                    block_bytes[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[56 + i] = msg_bits[8*i +: 8];
            compress_block();
            for (int i = 0; i < 4; i++) begin
                item.word = chain[i];
                item.index = 2'(i);
                item.last = (i == 3);
                digest_queue.push_back(item);
            end
            restart();
        endfunction

        function void check_word(logic [31:0] word, logic [1:0] index, logic last);
            digest_item_t want;
            if (digest_queue.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected digest item: word %h index %0d last %0b",
                             word, index, last);
                return;
            end
            want = digest_queue.pop_front();
            if (word !== want.word || index !== want.index || last !== want.last) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                             want.word, want.index, want.last, word, index, last);
            end
        endfunction

        function int unsigned pending();
            return digest_queue.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // data_byte
    logic        s_tuser = 1'b0;    // byte_valid
    logic        s_tlast = 1'b0;    // end_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // digest_word
    logic [1:0]  m_tuser;           // word_index
    logic        m_tlast;           // last_word

    digest_board board = new;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;

    md5_byte_stream_hasher_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == STOP_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: checks each digest item taken and switches among four random stall modes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                board.check_word(m_tdata, m_tuser, m_tlast);
            if (cycle_count % 256 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ((cycle_count / 5) % 3 != 0);
            endcase
        end
    end

    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic ends);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= has_byte;
        s_tlast <= ends;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_item(data, has_byte, ends);
        items_sent++;
        burst_left--;
    endtask

    task automatic send_message(input int unsigned n_bytes, input logic end_on_byte);
        for (int unsigned k = 0; k < n_bytes; k++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (k == n_bytes - 1));
        end
        if (!end_on_byte || n_bytes == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_for_digests();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int unsigned pick, n_bytes;
        board.restart();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message, then "abc" with the end flag on its last byte
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // idle items, then a single all-ones byte carrying the end flag
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        // zero byte then a separate end item with junk data
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        // eight alternating bytes
        for (int i = 0; i < 8; i++)
            send_item((i % 2 == 0) ? 8'haa : 8'h55, 1'b1, i == 7);
        wait_for_digests();

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                n_bytes = $urandom_range(0, 8);
            else if (pick < 8)
                n_bytes = $urandom_range(52, 72);
            else
                n_bytes = $urandom_range(110, 135);
            if (n_bytes >= ITEM_TARGET - items_sent)
                n_bytes = ITEM_TARGET - items_sent - 1;
            send_message(n_bytes, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                wait_for_digests();
        end

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/md5bs_pkg.sv
hw/rtl/md5bs_ram.sv
hw/rtl/md5bs_round.sv
hw/rtl/md5_byte_stream_hasher_unit.sv
hw/rtl/md5bs_checker.sv
bench/md5_byte_stream_hasher_unit_test.sv
